// ===== design/bmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types and codes for the bucket membership table.
// ----------------------------------------------------------------------------
package bmt_pkg;

  typedef enum logic [2:0] {
    CMD_REBUILD = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_MOVE    = 3'd2,
    CMD_KILL    = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_COUNT   = 3'd5,
    CMD_TOTAL   = 3'd6,
    CMD_MEMBERS = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NONE  = 3'd1,
    ST_BAD   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_POP  = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LATCH,
    UOP_CLR_ALL,
    UOP_CLR,
    UOP_POS_RD,
    UOP_CELL_RD,
    UOP_POP_ID,
    UOP_NEW_ID,
    UOP_UNLINK_A,
    UOP_UNLINK_B,
    UOP_LINK_A,
    UOP_LINK_B,
    UOP_FILL,
    UOP_FILL_END,
    UOP_WALK_START,
    UOP_WALK_RD,
    UOP_WALK_NX
  } uop_t;

  typedef enum logic [2:0] {
    VS_ZERO,
    VS_LIVE,
    VS_EID,
    VS_CNT,
    VS_CUR
  } vsel_t;

  typedef enum logic [1:0] {
    RC_ZERO,
    RC_POS,
    RC_IN
  } rcsel_t;

  typedef struct packed {
    uop_t    uop;
    logic    emit;
    status_t st;
    vsel_t   vsel;
    rcsel_t  rcsel;
    logic    walk_last;
    logic    take_stk;
    logic    inc_live;
    logic    kill;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic cell_ok;
    logic exists;
    logic same_cell;
    logic stk_any;
    logic alloc_full;
    logic head_empty;
    logic walk_last;
    logic clr_done;
    logic fill_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/bmt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_ctrl
// Command sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module bmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bmt_pkg::sts_t sts,
  output bmt_pkg::ctl_t      ctl
);

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_DEC  = 15'b000000000000100,
    S_ERR  = 15'b000000000001000,
    S_FIN  = 15'b000000000010000,
    S_UA   = 15'b000000000100000,
    S_UB   = 15'b000000001000000,
    S_CRD  = 15'b000000010000000,
    S_CRDS = 15'b000000100000000,
    S_LA   = 15'b000001000000000,
    S_LB   = 15'b000010000000000,
    S_FILL = 15'b000100000000000,
    S_WH   = 15'b001000000000000,
    S_WRD  = 15'b010000000000000,
    S_WEM  = 15'b100000000000000
  } state_t;

  state_t           state, state_next;
  logic             rb, rb_next;
  bmt_pkg::status_t err, err_next;

  always_comb begin
    state_next    = state;
    rb_next       = rb;
    err_next      = err;
    in_ready      = 1'b0;
    ctl.uop       = bmt_pkg::UOP_NONE;
    ctl.emit      = 1'b0;
    ctl.st        = bmt_pkg::ST_OK;
    ctl.vsel      = bmt_pkg::VS_ZERO;
    ctl.rcsel     = bmt_pkg::RC_ZERO;
    ctl.walk_last = 1'b0;
    ctl.take_stk  = 1'b0;
    ctl.inc_live  = 1'b0;
    ctl.kill      = 1'b0;
    unique case (state)
      S_CLR: begin
        ctl.uop = bmt_pkg::UOP_CLR;
        if (sts.clr_done) begin
          state_next = rb ? S_FILL : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.uop    = bmt_pkg::UOP_LATCH;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.cmd)
          bmt_pkg::CMD_REBUILD: begin
            if (!sts.cell_ok) begin
              err_next = bmt_pkg::ST_BAD; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_CLR_ALL; rb_next = 1'b1; state_next = S_CLR;
            end
          end
          bmt_pkg::CMD_CREATE: begin
            if (!sts.cell_ok) begin
              err_next = bmt_pkg::ST_BAD; state_next = S_ERR;
            end else if (sts.stk_any) begin
              ctl.uop = bmt_pkg::UOP_POP_ID; state_next = S_CRDS;
            end else if (!sts.alloc_full) begin
              ctl.uop = bmt_pkg::UOP_NEW_ID; state_next = S_CRD;
            end else begin
              err_next = bmt_pkg::ST_FULL; state_next = S_ERR;
            end
          end
          bmt_pkg::CMD_MOVE: begin
            if (!sts.exists) begin
              err_next = bmt_pkg::ST_NONE; state_next = S_ERR;
            end else if (!sts.cell_ok) begin
              err_next = bmt_pkg::ST_BAD; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_POS_RD; state_next = S_UA;
            end
          end
          bmt_pkg::CMD_KILL: begin
            if (!sts.exists) begin
              err_next = bmt_pkg::ST_NONE; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_POS_RD; state_next = S_UA;
            end
          end
          bmt_pkg::CMD_FIND: begin
            if (!sts.exists) begin
              err_next = bmt_pkg::ST_NONE; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_POS_RD; state_next = S_FIN;
            end
          end
          bmt_pkg::CMD_COUNT: begin
            if (!sts.cell_ok) begin
              err_next = bmt_pkg::ST_BAD; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_CELL_RD; state_next = S_FIN;
            end
          end
          bmt_pkg::CMD_TOTAL: begin
            state_next = S_FIN;
          end
          bmt_pkg::CMD_MEMBERS: begin
            if (!sts.cell_ok) begin
              err_next = bmt_pkg::ST_BAD; state_next = S_ERR;
            end else begin
              ctl.uop = bmt_pkg::UOP_CELL_RD; state_next = S_WH;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ERR: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          ctl.st     = err;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
          unique case (sts.cmd)
            bmt_pkg::CMD_CREATE:  ctl.vsel = bmt_pkg::VS_EID;
            bmt_pkg::CMD_REBUILD: ctl.vsel = bmt_pkg::VS_LIVE;
            bmt_pkg::CMD_TOTAL:   ctl.vsel = bmt_pkg::VS_LIVE;
            bmt_pkg::CMD_COUNT:   ctl.vsel = bmt_pkg::VS_CNT;
            bmt_pkg::CMD_FIND:    ctl.rcsel = bmt_pkg::RC_POS;
            default:              ctl.vsel = bmt_pkg::VS_ZERO;
          endcase
        end
      end
      S_UA: begin
        if (sts.cmd == bmt_pkg::CMD_MOVE && sts.same_cell) begin
          state_next = S_FIN;
        end else begin
          ctl.uop    = bmt_pkg::UOP_UNLINK_A;
          state_next = S_UB;
        end
      end
      S_UB: begin
        ctl.uop  = bmt_pkg::UOP_UNLINK_B;
        ctl.kill = (sts.cmd == bmt_pkg::CMD_KILL);
        state_next = ctl.kill ? S_FIN : S_CRD;
      end
      S_CRD: begin
        ctl.uop    = bmt_pkg::UOP_CELL_RD;
        state_next = S_LA;
      end
      S_CRDS: begin
        ctl.uop      = bmt_pkg::UOP_CELL_RD;
        ctl.take_stk = 1'b1;
        state_next   = S_LA;
      end
      S_LA: begin
        ctl.uop      = bmt_pkg::UOP_LINK_A;
        ctl.inc_live = (sts.cmd == bmt_pkg::CMD_CREATE);
        state_next   = S_LB;
      end
      S_LB: begin
        ctl.uop    = bmt_pkg::UOP_LINK_B;
        state_next = S_FIN;
      end
      S_FILL: begin
        if (sts.fill_done) begin
          ctl.uop    = bmt_pkg::UOP_FILL_END;
          rb_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          ctl.uop = bmt_pkg::UOP_FILL;
        end
      end
      S_WH: begin
        if (sts.head_empty) begin
          if (sts.out_free) begin
            ctl.emit   = 1'b1;
            ctl.st     = bmt_pkg::ST_EMPTY;
            ctl.rcsel  = bmt_pkg::RC_IN;
            state_next = S_IDLE;
          end
        end else begin
          ctl.uop    = bmt_pkg::UOP_WALK_START;
          state_next = S_WRD;
        end
      end
      S_WRD: begin
        ctl.uop    = bmt_pkg::UOP_WALK_RD;
        state_next = S_WEM;
      end
      S_WEM: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.vsel      = bmt_pkg::VS_CUR;
          ctl.rcsel     = bmt_pkg::RC_IN;
          ctl.walk_last = 1'b1;
          ctl.uop       = bmt_pkg::UOP_WALK_NX;
          state_next    = sts.walk_last ? S_IDLE : S_WRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      rb    <= 1'b0;
      err   <= bmt_pkg::ST_OK;
    end else begin
      state <= state_next;
      rb    <= rb_next;
      err   <= err_next;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> sts.out_free)
    else $error("result issued into a full output register");

endmodule
`default_nettype wire

// ===== design/bmt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_dp
// Datapath: cell and entity link memories, free stack, counters, result reg.
// ----------------------------------------------------------------------------
module bmt_dp #(
  parameter int MAX_PEOPLE = 64,
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [15:0]   in_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [6:0]    cfg_wdata,
  input  wire bmt_pkg::ctl_t ctl,
  output bmt_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_data,
  output logic               out_last
);

  localparam int IW     = $clog2(MAX_PEOPLE);
  localparam int LW     = $clog2(MAX_PEOPLE + 1);
  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam logic [LW-1:0] EMPTY = LW'(MAX_PEOPLE);

  logic [3:0] grid_rows, grid_cols;
  logic [6:0] init_pop;
  logic [LW-1:0] pop;

  bmt_pkg::cmd_t cmd_q;
  logic [5:0] x_q;
  logic [2:0] r_q, c_q;

  logic [LW-1:0] cnt_mem  [NCELLS];
  logic [LW-1:0] head_mem [NCELLS];
  logic [LW-1:0] nxt_mem  [MAX_PEOPLE];
  logic [LW-1:0] prv_mem  [MAX_PEOPLE];
  logic [5:0]    pos_mem  [MAX_PEOPLE];
  logic [IW-1:0] stk_mem  [MAX_PEOPLE];

  logic [LW-1:0] cnt_q, head_q, nxt_q, prv_q;
  logic [5:0]    pos_q;
  logic [IW-1:0] stk_q;

  logic [MAX_PEOPLE-1:0] alive;
  logic [LW-1:0] free_top, alloc, live, fill, cur, wcnt, top_m1;
  logic [IW-1:0] eid;
  logic [CW-1:0] swp, k_in, k_old;

  logic          cell_we, cell_re;
  logic [CW-1:0] cell_wa, cell_ra;
  logic [LW-1:0] cell_wcnt, cell_whead;
  logic          nxt_we, nxt_re, prv_we, prv_re, pos_we, pos_re, stk_we, stk_re;
  logic [IW-1:0] nxt_wa, nxt_ra, prv_wa, pos_wa, stk_wa, stk_ra;
  logic [LW-1:0] nxt_wd, prv_wd;
  logic          push_ok;

  logic [2:0] o_st, o_row, o_col;
  logic [6:0] o_val;
  logic       o_last;

  assign pop    = LW'((32'(init_pop) > MAX_PEOPLE) ? MAX_PEOPLE : 32'(init_pop));
  assign k_in   = CW'(32'(r_q) * MAX_COLS + 32'(c_q));
  assign k_old  = CW'(32'(pos_q[5:3]) * MAX_COLS + 32'(pos_q[2:0]));
  assign top_m1 = free_top - LW'(1);
  assign push_ok = 32'(free_top) < MAX_PEOPLE;

  assign sts.cmd        = cmd_q;
  assign sts.cell_ok    = (32'(r_q) < 32'(grid_rows)) && (32'(r_q) < MAX_ROWS) &&
                          (32'(c_q) < 32'(grid_cols)) && (32'(c_q) < MAX_COLS);
  assign sts.exists     = (32'(x_q) < 32'(alloc)) && alive[x_q[IW-1:0]];
  assign sts.same_cell  = (pos_q == {r_q, c_q});
  assign sts.stk_any    = (free_top != '0);
  assign sts.alloc_full = (32'(alloc) >= MAX_PEOPLE);
  assign sts.head_empty = (head_q >= EMPTY);
  assign sts.walk_last  = (nxt_q >= EMPTY) || (32'(wcnt) + 32'd1 >= MAX_PEOPLE);
  assign sts.clr_done   = (swp == CW'(NCELLS - 1));
  assign sts.fill_done  = (fill == pop);
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    cell_we = 1'b0; cell_wa = k_in; cell_wcnt = '0; cell_whead = EMPTY;
    cell_re = 1'b0; cell_ra = k_in;
    nxt_we = 1'b0; nxt_wa = eid; nxt_wd = EMPTY; nxt_re = 1'b0; nxt_ra = x_q[IW-1:0];
    prv_we = 1'b0; prv_wa = eid; prv_wd = EMPTY; prv_re = 1'b0;
    pos_we = 1'b0; pos_wa = eid; pos_re = 1'b0;
    stk_we = 1'b0; stk_wa = free_top[IW-1:0]; stk_re = 1'b0; stk_ra = top_m1[IW-1:0];
    unique case (ctl.uop)
      bmt_pkg::UOP_CLR: begin
        cell_we = 1'b1; cell_wa = swp;
      end
      bmt_pkg::UOP_POS_RD: begin
        pos_re = 1'b1; nxt_re = 1'b1; prv_re = 1'b1;
      end
      bmt_pkg::UOP_CELL_RD: cell_re = 1'b1;
      bmt_pkg::UOP_POP_ID:  stk_re  = 1'b1;
      bmt_pkg::UOP_UNLINK_A: begin
        cell_re = 1'b1; cell_ra = k_old;
        nxt_we  = (prv_q < EMPTY); nxt_wa = prv_q[IW-1:0]; nxt_wd = nxt_q;
        prv_we  = (nxt_q < EMPTY); prv_wa = nxt_q[IW-1:0]; prv_wd = prv_q;
      end
      bmt_pkg::UOP_UNLINK_B: begin
        cell_we    = 1'b1; cell_wa = k_old;
        cell_wcnt  = cnt_q - LW'(1);
        cell_whead = (prv_q < EMPTY) ? head_q : nxt_q;
        stk_we     = ctl.kill && push_ok;
      end
      bmt_pkg::UOP_LINK_A: begin
        cell_we = 1'b1; cell_wcnt = cnt_q + LW'(1); cell_whead = LW'(eid);
        nxt_we  = 1'b1; nxt_wd = head_q;
        prv_we  = 1'b1;
        pos_we  = 1'b1;
      end
      bmt_pkg::UOP_LINK_B: begin
        prv_we = (head_q < EMPTY); prv_wa = head_q[IW-1:0]; prv_wd = LW'(eid);
      end
      bmt_pkg::UOP_FILL: begin
        nxt_we = 1'b1; nxt_wa = fill[IW-1:0];
        nxt_wd = (fill == '0) ? EMPTY : fill - LW'(1);
        prv_we = 1'b1; prv_wa = fill[IW-1:0];
        prv_wd = (fill + LW'(1) == pop) ? EMPTY : fill + LW'(1);
        pos_we = 1'b1; pos_wa = fill[IW-1:0];
      end
      bmt_pkg::UOP_FILL_END: begin
        cell_we = 1'b1; cell_wcnt = pop;
        cell_whead = (pop != '0) ? pop - LW'(1) : EMPTY;
      end
      bmt_pkg::UOP_WALK_RD: begin
        nxt_re = 1'b1; nxt_ra = cur[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cnt_mem[cell_wa]  <= cell_wcnt;
      head_mem[cell_wa] <= cell_whead;
    end
    if (cell_re) begin
      cnt_q  <= cnt_mem[cell_ra];
      head_q <= head_mem[cell_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_q <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (prv_re) prv_q <= prv_mem[x_q[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= {r_q, c_q};
    if (pos_re) pos_q <= pos_mem[x_q[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= eid;
    if (stk_re) stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 4'd8;
      grid_cols <= 4'd8;
      init_pop  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmt_pkg::CFG_ROWS: grid_rows <= cfg_wdata[3:0];
        bmt_pkg::CFG_COLS: grid_cols <= cfg_wdata[3:0];
        bmt_pkg::CFG_POP:  init_pop  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.uop == bmt_pkg::UOP_LATCH) begin
      cmd_q <= bmt_pkg::cmd_t'(in_data[2:0]);
      x_q   <= in_data[8:3];
      r_q   <= in_data[11:9];
      c_q   <= in_data[14:12];
    end
    unique case (ctl.uop)
      bmt_pkg::UOP_POS_RD:     eid <= x_q[IW-1:0];
      bmt_pkg::UOP_NEW_ID:     eid <= alloc[IW-1:0];
      bmt_pkg::UOP_CELL_RD:    if (ctl.take_stk) eid <= stk_q;
      bmt_pkg::UOP_WALK_START: begin
        cur  <= head_q;
        wcnt <= '0;
      end
      bmt_pkg::UOP_WALK_NX: begin
        cur  <= nxt_q;
        wcnt <= wcnt + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive    <= '0;
      free_top <= '0;
      alloc    <= '0;
      live     <= '0;
      swp      <= '0;
      fill     <= '0;
    end else begin
      unique case (ctl.uop)
        bmt_pkg::UOP_CLR_ALL: begin
          alive    <= '0;
          free_top <= '0;
          alloc    <= '0;
          live     <= '0;
          swp      <= '0;
          fill     <= '0;
        end
        bmt_pkg::UOP_CLR:    swp <= swp + CW'(1);
        bmt_pkg::UOP_POP_ID: free_top <= top_m1;
        bmt_pkg::UOP_NEW_ID: alloc <= alloc + LW'(1);
        bmt_pkg::UOP_UNLINK_B: begin
          if (ctl.kill) begin
            alive[eid] <= 1'b0;
            live       <= live - LW'(1);
            if (push_ok) free_top <= free_top + LW'(1);
          end
        end
        bmt_pkg::UOP_LINK_A: begin
          alive[eid] <= 1'b1;
          if (ctl.inc_live) live <= live + LW'(1);
        end
        bmt_pkg::UOP_FILL: begin
          alive[fill[IW-1:0]] <= 1'b1;
          fill <= fill + LW'(1);
        end
        bmt_pkg::UOP_FILL_END: begin
          alloc <= pop;
          live  <= pop;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      o_st   <= ctl.st;
      o_last <= ctl.walk_last ? sts.walk_last : 1'b1;
      unique case (ctl.vsel)
        bmt_pkg::VS_LIVE: o_val <= 7'(live);
        bmt_pkg::VS_EID:  o_val <= 7'(eid);
        bmt_pkg::VS_CNT:  o_val <= 7'(cnt_q);
        bmt_pkg::VS_CUR:  o_val <= 7'(cur);
        default:          o_val <= '0;
      endcase
      unique case (ctl.rcsel)
        bmt_pkg::RC_POS: begin
          o_row <= pos_q[5:3];
          o_col <= pos_q[2:0];
        end
        bmt_pkg::RC_IN: begin
          o_row <= r_q;
          o_col <= c_q;
        end
        default: begin
          o_row <= '0;
          o_col <= '0;
        end
      endcase
    end
  end

  assign out_data = {o_col, o_row, o_val, o_st};
  assign out_last = o_last;

  a_live_le_alloc: assert property (@(posedge clk) disable iff (rst)
    32'(free_top) + 32'(live) <= 32'(alloc))
    else $error("free stack plus live entities exceed allocated IDs");

  a_alloc_cap: assert property (@(posedge clk) disable iff (rst)
    (ctl.uop == bmt_pkg::UOP_NEW_ID) |=> (32'(alloc) <= MAX_PEOPLE))
    else $error("allocated IDs beyond capacity");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> out_valid)
    else $error("result register lost an item");

endmodule
`default_nettype wire

// ===== design/bucket_membership_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_membership_table
// Grid cell membership table with per-cell linked member lists.
// ----------------------------------------------------------------------------
// One item is worked at a time. Find reads the position of the person; cell count
// reads the cell. Create takes an ID from the free stack or a new one, reads the
// cell and links the person in; kill reads the position and unlinks; move unlinks
// and links again, but skips both when the cell is the same. Each step is one
// access to the link and cell memories. Member listing reads the cell head and
// then the next link once per member. Rebuild sweeps the cell memory, then writes
// one entity per cycle; after reset the same sweep runs with no item taken. A
// result waits in an output register while the next item is accepted.
module bucket_membership_table #(
  parameter int MAX_PEOPLE = 64,
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // command, person, in_row, in_col, pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // status, value, out_row, out_col
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [6:0]  cfg_wdata
);

  bmt_pkg::ctl_t ctl;
  bmt_pkg::sts_t sts;

  bmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bmt_dp #(
    .MAX_PEOPLE (MAX_PEOPLE),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire
